### hw/rtl/cwss_pkg.sv
// Shared types, constants and sine table generator for the chirp segment synthesizer.
package cwss_pkg;

  // Defaults for the top-level parameters
  localparam int LUT_BITS_DEF   = 8;
  localparam int INDEX_BITS_DEF = 20;
  localparam int MIX_BITS_DEF   = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Arithmetic widths
  localparam int MUL_W  = 33;           // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;    // full signed product
  localparam int ADD_W  = PROD_W - 31;  // product after the Q31 scaling shift
  localparam int WAVE_W = 18;           // waveform sample, -98304..32768

  localparam logic signed [WAVE_W-1:0] WAVE_ONE = 18'sd32768;

  // Sine table generation
  localparam int                SINE_SCALE = 32700;
  localparam longint unsigned   TWO_PI_Q32 = 64'd26986075409;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_PHASE = 3'd0,
    REG_START_STEP  = 3'd1,
    REG_CHIRP_RATE  = 3'd2,
    REG_START_AMP   = 3'd3,
    REG_AMP_STEP    = 3'd4,
    REG_PULSE_WIDTH = 3'd5,
    REG_WAVEFORM    = 3'd6,
    REG_SEG_LENGTH  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_ASIN     = 3'd4,
    WAVE_PARABOLA = 3'd5,
    WAVE_QUANT    = 3'd6,
    WAVE_PULSE    = 3'd7
  } wave_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } seq_state_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;  // take an input transfer
    logic lut_en;    // register table operands
    logic mul_en;    // load the shared multiplier product
    logic mul_amp;   // multiplier computes amplitude times waveform
    logic commit;    // emit result and advance segment state
  } seq_ctl_t;

  // One quarter-wave sample in Q28 by a truncated Taylor series, scaled to 32700
  function automatic logic signed [15:0] quarter_sine(input int q, input int lut_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (64'(q) * TWO_PI_Q32) >> (lut_bits + 4);
    x2   = (x * x) >> 28;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 28;
      case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        6:       term = term / 156;
        7:       term = term / 210;
        default: term = term / 272;
      endcase
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) <<< 28)) begin
      sum = longint'(1) <<< 28;
    end
    return 16'((unsigned'(sum) * 64'(SINE_SCALE)) >> 28);
  endfunction

  // Full-wave table entry, folded from the quarter wave with forced zero and peaks
  function automatic logic signed [15:0] sine_entry(input int i, input int lut_bits);
    int                 n;
    int                 qtr;
    int                 half;
    logic signed [15:0] v;
    n    = 1 << lut_bits;
    qtr  = n >> 2;
    half = n >> 1;
    if (i <= qtr) begin
      v = quarter_sine(i, lut_bits);
    end else if (i <= half) begin
      v = quarter_sine(half - i, lut_bits);
    end else if (i <= half + qtr) begin
      v = -quarter_sine(i - half, lut_bits);
    end else begin
      v = -quarter_sine(n - i, lut_bits);
    end
    if (i == 0 || i == half || i == n) begin
      v = '0;
    end else if (i == qtr) begin
      v = 16'(SINE_SCALE);
    end else if (i == half + qtr) begin
      v = -16'(SINE_SCALE);
    end
    return v;
  endfunction

endpackage

### hw/rtl/chirp_waveform_segment_synth.sv
// Chirp oscillator segment synthesizer: config, segment state, waveform and mix datapath.
//
// Usage: each input transfer (in_tdata = mix sample, in_tuser = restart) yields one
// output transfer (out_tdata = mixed, saturated sample, out_tlast = final sample of the
// segment). Registers are written through the cfg_ channel (always ready); the start
// registers are picked up at the next restart or segment end, the others at once.
// Steps: an item passes through accept, table read, two passes through the one shared
// 33x33 multiplier and commit; a new sample is accepted only after the last one commits,
// and the result is loaded into the output register at the commit step.
// in_tready is high only while the sequencer is idle.
// Stall: a finished result waits in the output register; the next item is accepted and
// processed meanwhile, and holds at the commit step until the output register is free.
// Reset (rst_n low, synchronous) loads the register defaults (unity amplitude, sine,
// half-duty pulse, one-sample segments), reloads the segment state and empties the
// output register.
module chirp_waveform_segment_synth
  import cwss_pkg::*;
#(
  parameter int LUT_BITS   = LUT_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int MIX_BITS   = MIX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((MIX_BITS+7)/8)*8-1:0]       in_tdata,   // [MIX_BITS-1:0] mix_in
  input  logic                                in_tuser,   // [0] restart
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((MIX_BITS+7)/8)*8-1:0]       out_tdata,  // [MIX_BITS-1:0] mix_out
  output logic                                out_tlast,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data
);

  localparam int TDATA_W = ((MIX_BITS + 7) / 8) * 8;
  localparam int SUM_W   = ((MIX_BITS > ADD_W) ? MIX_BITS : ADD_W) + 1;
  localparam int CMP_W   = ((INDEX_BITS + 1) > 20) ? (INDEX_BITS + 1) : 20;
  localparam logic signed [SUM_W-1:0] MIX_HI = SUM_W'((longint'(1) <<< (MIX_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] MIX_LO = -MIX_HI - SUM_W'(1);

  // configuration registers
  logic [31:0]  start_phase_r;
  logic [31:0]  start_step_r;
  logic [30:0]  chirp_rate_r;
  logic [31:0]  start_amp_r;
  logic [31:0]  amp_step_r;
  logic [16:0]  pulse_width_r;
  wave_t        waveform_r;
  logic [19:0]  seg_length_r;

  // segment state
  logic [31:0]           phase_r;
  logic [31:0]           phase_nxt;
  logic [31:0]           step_r;
  logic [31:0]           step_nxt;
  logic [31:0]           amp_r;
  logic [31:0]           amp_nxt;
  logic [INDEX_BITS-1:0] idx_r;
  logic [INDEX_BITS-1:0] idx_nxt;

  // datapath
  seq_ctl_t                   ctl;
  logic                       in_fire;
  logic                       out_free;
  logic signed [MIX_BITS-1:0] mix_r;
  logic signed [15:0]         s0_r;
  logic signed [16:0]         diff_r;
  logic [7:0]                 frac_r;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic [31:0]                s_w;
  logic [31:0]                abs_w;
  logic signed [WAVE_W-1:0]   wave_w;
  logic signed [ADD_W-1:0]    add_w;
  logic signed [SUM_W-1:0]    sum_w;
  logic [MIX_BITS-1:0]        mix_sat;
  logic [INDEX_BITS:0]        idx_inc;
  logic                       last_w;
  logic [31:0]                chirp_ext;

  logic                       out_tvalid_r;
  logic [TDATA_W-1:0]         out_tdata_r;
  logic                       out_tlast_r;

  cwss_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  cwss_sine_rom #(
    .LUT_BITS (LUT_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (ctl.lut_en),
    .phase  (phase_r),
    .s0_r   (s0_r),
    .diff_r (diff_r),
    .frac_r (frac_r)
  );

  cwss_mul u_mul (
    .clk    (clk),
    .en     (ctl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_tready = ctl.in_ready;
  assign in_fire   = in_tvalid && ctl.in_ready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_phase_r <= '0;
      start_step_r  <= '0;
      chirp_rate_r  <= '0;
      start_amp_r   <= 32'h0001_0000;
      amp_step_r    <= '0;
      pulse_width_r <= 17'd32768;
      waveform_r    <= WAVE_SINE;
      seg_length_r  <= 20'd1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_PHASE: start_phase_r <= cfg_data;
        REG_START_STEP:  start_step_r  <= cfg_data;
        REG_CHIRP_RATE:  chirp_rate_r  <= cfg_data[30:0];
        REG_START_AMP:   start_amp_r   <= cfg_data;
        REG_AMP_STEP:    amp_step_r    <= cfg_data;
        REG_PULSE_WIDTH: pulse_width_r <= cfg_data[16:0];
        REG_WAVEFORM:    waveform_r    <= wave_t'(cfg_data[2:0]);
        REG_SEG_LENGTH:  seg_length_r  <= cfg_data[19:0];
        default:         ;
      endcase
    end
  end

  // Latch the mix sample on transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mix_r <= in_tdata[MIX_BITS-1:0];
    end
  end

  // Phase offset by half a turn, and its magnitude
  assign s_w   = phase_r ^ 32'h8000_0000;
  assign abs_w = s_w[31] ? (~s_w + 32'd1) : s_w;

  // Form the waveform sample from the table sample, the first product and the phase
  always_comb begin
    case (waveform_r)
      WAVE_SAW: begin
        wave_w = -WAVE_W'(signed'(s_w) >>> 16);
      end
      WAVE_SQUARE: begin
        wave_w = (signed'(s_w) > 32'sd0) ? WAVE_ONE : -WAVE_ONE;
      end
      WAVE_TRIANGLE: begin
        wave_w = WAVE_W'(19'sd32768 - signed'({1'b0, abs_w[31:14]}));
      end
      WAVE_PARABOLA: begin
        wave_w = WAVE_W'(19'sd32768 - signed'({2'b00, prod_r[63:47]}));
      end
      WAVE_PULSE: begin
        if (pulse_width_r == '0) begin
          wave_w = WAVE_ONE;
        end else if ({1'b0, phase_r} < {pulse_width_r, 16'h0000}) begin
          wave_w = WAVE_ONE;
        end else begin
          wave_w = -WAVE_ONE;
        end
      end
      default: begin
        wave_w = WAVE_W'(s0_r) + WAVE_W'(prod_r >>> 8);
      end
    endcase
  end

  // Select multiplier operands: waveform pass, then amplitude pass
  always_comb begin
    if (ctl.mul_amp) begin
      mul_a = MUL_W'(signed'(amp_r));
      mul_b = MUL_W'(wave_w);
    end else if (waveform_r == WAVE_PARABOLA) begin
      mul_a = signed'({1'b0, abs_w});
      mul_b = signed'({1'b0, abs_w});
    end else begin
      mul_a = MUL_W'(diff_r);
      mul_b = signed'({{(MUL_W-8){1'b0}}, frac_r});
    end
  end

  // Scale, add onto the mix sample and saturate
  assign add_w = prod_r[PROD_W-1:31];
  assign sum_w = SUM_W'(mix_r) + SUM_W'(add_w);

  always_comb begin
    if (sum_w > MIX_HI) begin
      mix_sat = MIX_BITS'(MIX_HI);
    end else if (sum_w < MIX_LO) begin
      mix_sat = MIX_BITS'(MIX_LO);
    end else begin
      mix_sat = MIX_BITS'(sum_w);
    end
  end

  // End of segment
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign last_w  = CMP_W'(idx_inc) >= CMP_W'(seg_length_r);

  // Reload on restart or segment end, otherwise advance
  assign chirp_ext = {chirp_rate_r[30], chirp_rate_r};

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    amp_nxt   = amp_r;
    idx_nxt   = idx_r;
    if ((in_fire && in_tuser) || (ctl.commit && last_w)) begin
      phase_nxt = start_phase_r;
      step_nxt  = start_step_r + chirp_ext;
      amp_nxt   = start_amp_r;
      idx_nxt   = '0;
    end else if (ctl.commit) begin
      phase_nxt = phase_r + step_r;
      step_nxt  = step_r + {chirp_rate_r, 1'b0};
      amp_nxt   = amp_r + amp_step_r;
      idx_nxt   = idx_inc[INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
      amp_r   <= 32'h0001_0000;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      amp_r   <= amp_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Output register: load on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_tdata_r <= TDATA_W'(mix_sat);
      out_tlast_r <= last_w;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

### hw/rtl/cwss_sine_rom.sv
// Constant sine table with registered interpolation operands.
module cwss_sine_rom
  import cwss_pkg::*;
#(
  parameter int LUT_BITS = LUT_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         phase,
  output logic signed [15:0]  s0_r,
  output logic signed [16:0]  diff_r,
  output logic [7:0]          frac_r
);

  localparam int LUT_SIZE = 1 << LUT_BITS;
  localparam int FB       = 16 - LUT_BITS;

  logic signed [15:0]  lut_w [LUT_SIZE+1];
  logic [LUT_BITS:0]   idx_lo;
  logic [LUT_BITS:0]   idx_hi;
  logic [23:0]         frac_ext;
  logic signed [15:0]  s0_w;
  logic signed [15:0]  s1_w;

  // Build the table as constant logic
  for (genvar g = 0; g <= LUT_SIZE; g++) begin : g_lut
    localparam logic signed [15:0] ENTRY = sine_entry(g, LUT_BITS);
    assign lut_w[g] = ENTRY;
  end

  // Split the top 16 phase bits into table index and 8-bit fraction
  assign idx_lo   = {1'b0, phase[31 -: LUT_BITS]};
  assign idx_hi   = idx_lo + 1'b1;
  assign frac_ext = {phase[31:16], 8'h00} >> FB;
  assign s0_w     = lut_w[idx_lo];
  assign s1_w     = lut_w[idx_hi];

  // Hold neighbor sample and slope for the multiplier
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r   <= s0_w;
      diff_r <= 17'(s1_w) - 17'(s0_w);
      frac_r <= frac_ext[7:0];
    end
  end

endmodule

### hw/rtl/cwss_mul.sv
// Shared signed multiplier with registered product.
module cwss_mul
  import cwss_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod_r
);

  // Load the product when the sequencer asks
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

### hw/rtl/cwss_seq.sv
// Per-sample sequencer: table read, two multiplier passes, result commit.
module cwss_seq
  import cwss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  output seq_ctl_t ctl
);

  seq_state_t state_r;
  seq_state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_LOAD: ctl.lut_en   = 1'b1;
      ST_MUL1: ctl.mul_en   = 1'b1;
      ST_MUL2: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_amp = 1'b1;
      end
      ST_DONE: ctl.commit = out_free;
      default: ctl = '0;
    endcase
  end

endmodule
